@@ src/gbci_pkg.sv @@
`timescale 1ns / 1ps

package gbci_pkg;

  // field widths
  localparam int RATE_W    = 16;
  localparam int ANGLE_W   = 48;
  localparam int TIME_W    = 32;
  localparam int CNT_W     = 16;
  localparam int DELTA_W   = 16;
  localparam int AXSEL_W   = 3;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int NUM_AX    = 3;
  localparam int AX_W      = 2;

  // derived datapath widths
  localparam int SUM_W  = RATE_W + CNT_W;
  localparam int DIFF_W = RATE_W + 1;
  localparam int PROD_W = DIFF_W + DELTA_W + 1;
  localparam int ADD_W  = ((ANGLE_W > PROD_W) ? ANGLE_W : PROD_W) + 1;

  // stream packing
  localparam int IN_DATA_W  = ((NUM_AX * RATE_W + TIME_W + 7) / 8) * 8;
  localparam int IN_USER_W  = OP_W;
  localparam int OUT_DATA_W = ((NUM_AX * ANGLE_W + 7) / 8) * 8;
  localparam int OUT_USER_W = 2;

  // item kinds
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_CAL    = 2'd1;
  localparam logic [OP_W-1:0] OP_ZERO   = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROLL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_YAW   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL   = 2'd3;

  // axis selector codes
  localparam logic [AXSEL_W-1:0] AXIS_X  = 3'd0;
  localparam logic [AXSEL_W-1:0] AXIS_Y  = 3'd1;
  localparam logic [AXSEL_W-1:0] AXIS_Z  = 3'd2;
  localparam logic [AXSEL_W-1:0] AXIS_NX = 3'd3;
  localparam logic [AXSEL_W-1:0] AXIS_NY = 3'd4;
  localparam logic [AXSEL_W-1:0] AXIS_NZ = 3'd5;

  typedef struct packed {
    logic load;
    logic neg;
  } mac_ctrl_t;

endpackage

@@ src/gyro_bias_calibrate_integrate.sv @@
`timescale 1ns / 1ps

// Channel   Group          Contents
// input     s_axis_*       tuser: op; tdata: rate_x, rate_y, rate_z, time_ms
// output    m_axis_*       tuser: valid_res, calibrating; tdata: roll, pitch, yaw angles
// config    cfg_*          index 0 roll axis, 1 pitch axis, 2 yaw axis, 3 cal_samples
//
// One item at a time through a small sequencer. Tracking sample: one multiply and one
// saturating add per angle (shared unit). Calibration sample: one shared adder over the
// three sums; the last one adds a bit-serial bias divide per axis. Other items go straight
// to output. The next item is taken while a result waits in the output register; the block
// holds in the output state if that is still full. Reset is asynchronous, active low, and
// clears control, sums, bias and angles, not rates, delta or output data; no clearing pass.

module gyro_bias_calibrate_integrate (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [gbci_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // rate_x, rate_y, rate_z, time_ms
  input  logic [gbci_pkg::IN_USER_W-1:0]      s_axis_tuser,  // op
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [gbci_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // roll, pitch, yaw angle
  output logic [gbci_pkg::OUT_USER_W-1:0]     m_axis_tuser,  // valid_res, calibrating
  input  logic                                cfg_we_i,
  input  logic [gbci_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gbci_pkg::CFG_W-1:0]          cfg_data_i
);
  import gbci_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [AX_W-1:0] ax_q, ax_d;
  logic phase_q, phase_d;
  logic div_go_q, div_go_d;
  logic upd_q, upd_d;

  logic [AXSEL_W-1:0] axis_q [NUM_AX];
  logic [CNT_W-1:0]   cal_samples_q;

  logic                     cal_active_q, cal_active_d;
  logic [CNT_W-1:0]         cal_count_q, cal_count_d;
  logic signed [SUM_W-1:0]  sums_q [NUM_AX];
  logic signed [SUM_W-1:0]  sums_d [NUM_AX];
  logic signed [RATE_W-1:0] bias_q [NUM_AX];
  logic signed [RATE_W-1:0] bias_d [NUM_AX];
  logic signed [ANGLE_W-1:0] acc_q [NUM_AX];
  logic signed [ANGLE_W-1:0] acc_d [NUM_AX];
  logic [TIME_W-1:0]        last_q, last_d;
  logic                     have_q, have_d;
  logic [DELTA_W-1:0]       delta_q, delta_d;
  logic signed [RATE_W-1:0] rate_q [NUM_AX];
  logic signed [RATE_W-1:0] rate_d [NUM_AX];

  logic                      m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0]     m_data_q, m_data_d;
  logic [OUT_USER_W-1:0]     m_user_q, m_user_d;

  logic [TIME_W-1:0]   now, elapsed;
  logic [CNT_W-1:0]    target;
  logic                accept;
  logic [AXSEL_W-1:0]  sel;
  logic [AX_W-1:0]     src;
  logic                src_en;
  logic                src_neg;
  mac_ctrl_t           mac_ctrl;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [ANGLE_W-1:0] mac_sum;
  logic                div_start, div_done;
  logic signed [RATE_W-1:0] div_quot;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q[0]     <= AXIS_X;
      axis_q[1]     <= AXIS_Y;
      axis_q[2]     <= AXIS_Z;
      cal_samples_q <= CNT_W'(1000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROLL:  axis_q[0]     <= cfg_data_i[AXSEL_W-1:0];
        REG_PITCH: axis_q[1]     <= cfg_data_i[AXSEL_W-1:0];
        REG_YAW:   axis_q[2]     <= cfg_data_i[AXSEL_W-1:0];
        REG_CAL:   cal_samples_q <= cfg_data_i[CNT_W-1:0];
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign now           = s_axis_tdata[NUM_AX*RATE_W +: TIME_W];
  assign elapsed       = now - last_q;
  assign target        = (cal_samples_q == '0) ? CNT_W'(1) : cal_samples_q;

  // axis select for the angle in work
  always_comb begin
    sel     = axis_q[ax_q];
    src     = '0;
    src_en  = 1'b1;
    src_neg = 1'b0;
    unique case (sel)
      AXIS_X:  src = 2'd0;
      AXIS_Y:  src = 2'd1;
      AXIS_Z:  src = 2'd2;
      AXIS_NX: begin src = 2'd0; src_neg = 1'b1; end
      AXIS_NY: begin src = 2'd1; src_neg = 1'b1; end
      AXIS_NZ: begin src = 2'd2; src_neg = 1'b1; end
      default: src_en = 1'b0;
    endcase
    diff = {rate_q[src][RATE_W-1], rate_q[src]} - {bias_q[src][RATE_W-1], bias_q[src]};
  end

  always_comb begin
    state_d      = state_q;
    ax_d         = ax_q;
    phase_d      = phase_q;
    div_go_d     = div_go_q;
    upd_d        = upd_q;
    cal_active_d = cal_active_q;
    cal_count_d  = cal_count_q;
    sums_d       = sums_q;
    bias_d       = bias_q;
    acc_d        = acc_q;
    last_d       = last_q;
    have_d       = have_q;
    delta_d      = delta_q;
    rate_d       = rate_q;
    m_valid_d    = m_valid_q;
    m_data_d     = m_data_q;
    m_user_d     = m_user_q;
    mac_ctrl.load = 1'b0;
    mac_ctrl.neg  = src_neg;
    div_start    = 1'b0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          for (int i = 0; i < NUM_AX; i++) begin
            rate_d[i] = s_axis_tdata[i*RATE_W +: RATE_W];
          end
          upd_d = 1'b0;
          ax_d  = '0;
          state_d = S_OUT;
          unique case (s_axis_tuser)
            OP_CAL: begin
              cal_active_d = 1'b1;
              cal_count_d  = '0;
              for (int i = 0; i < NUM_AX; i++) begin
                sums_d[i] = '0;
                bias_d[i] = '0;
              end
            end
            OP_ZERO: begin
              for (int i = 0; i < NUM_AX; i++) begin
                acc_d[i] = '0;
              end
            end
            OP_SAMPLE: begin
              if (cal_active_q) begin
                cal_count_d = cal_count_q + 1'b1;
                state_d     = S_SUM;
              end else if (!have_q) begin
                have_d = 1'b1;
                last_d = now;
              end else begin
                // delta saturates at the 16-bit limit
                delta_d = (|elapsed[TIME_W-1:DELTA_W]) ? '1 : elapsed[DELTA_W-1:0];
                last_d  = now;
                upd_d   = 1'b1;
                phase_d = 1'b0;
                state_d = S_MUL;
              end
            end
            OP_NONE: ;
          endcase
        end
      end

      S_SUM: begin
        sums_d[ax_q] = sums_q[ax_q]
                     + {{(SUM_W - RATE_W){rate_q[ax_q][RATE_W-1]}}, rate_q[ax_q]};
        if (ax_q == AX_W'(NUM_AX - 1)) begin
          ax_d     = '0;
          div_go_d = 1'b0;
          state_d  = (cal_count_q >= target) ? S_DIV : S_OUT;
        end else begin
          ax_d = ax_q + 1'b1;
        end
      end

      S_DIV: begin
        if (!div_go_q) begin
          div_start = 1'b1;
          div_go_d  = 1'b1;
        end else if (div_done) begin
          bias_d[ax_q] = div_quot;
          acc_d[ax_q]  = '0;
          div_go_d     = 1'b0;
          if (ax_q == AX_W'(NUM_AX - 1)) begin
            cal_active_d = 1'b0;
            state_d      = S_OUT;
          end else begin
            ax_d = ax_q + 1'b1;
          end
        end
      end

      S_MUL: begin
        if (!phase_q) begin
          mac_ctrl.load = 1'b1;
          phase_d       = 1'b1;
        end else begin
          if (src_en) begin
            acc_d[ax_q] = mac_sum;
          end
          phase_d = 1'b0;
          if (ax_q == AX_W'(NUM_AX - 1)) begin
            state_d = S_OUT;
          end else begin
            ax_d = ax_q + 1'b1;
          end
        end
      end

      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = '0;
          for (int i = 0; i < NUM_AX; i++) begin
            m_data_d[i*ANGLE_W +: ANGLE_W] = acc_q[i];
          end
          m_user_d = {cal_active_q, upd_q};
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ax_q         <= '0;
      phase_q      <= 1'b0;
      div_go_q     <= 1'b0;
      upd_q        <= 1'b0;
      cal_active_q <= 1'b0;
      cal_count_q  <= '0;
      last_q       <= '0;
      have_q       <= 1'b0;
      m_valid_q    <= 1'b0;
      for (int i = 0; i < NUM_AX; i++) begin
        sums_q[i] <= '0;
        bias_q[i] <= '0;
        acc_q[i]  <= '0;
      end
    end else begin
      state_q      <= state_d;
      ax_q         <= ax_d;
      phase_q      <= phase_d;
      div_go_q     <= div_go_d;
      upd_q        <= upd_d;
      cal_active_q <= cal_active_d;
      cal_count_q  <= cal_count_d;
      last_q       <= last_d;
      have_q       <= have_d;
      m_valid_q    <= m_valid_d;
      sums_q       <= sums_d;
      bias_q       <= bias_d;
      acc_q        <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q  <= delta_d;
    rate_q   <= rate_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  gbci_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sums_q[ax_q]),
    .divisor_i  (cal_count_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  gbci_mac u_mac (
    .clk_i   (clk_i),
    .ctrl_i  (mac_ctrl),
    .diff_i  (diff),
    .delta_i (delta_q),
    .acc_i   (acc_q[ax_q]),
    .sum_o   (mac_sum)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

@@ src/gbci_div.sv @@
`timescale 1ns / 1ps

module gbci_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [gbci_pkg::SUM_W-1:0]    dividend_i,
  input  logic        [gbci_pkg::CNT_W-1:0]    divisor_i,
  output logic                                 done_o,
  output logic signed [gbci_pkg::RATE_W-1:0]   quot_o
);
  import gbci_pkg::*;

  localparam int DCNT_W = $clog2(SUM_W + 1);

  logic              busy_q;
  logic [DCNT_W-1:0] cnt_q;
  logic              neg_q;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  div_q;
  logic [CNT_W:0]    shifted, trial;
  logic              fits;
  logic [SUM_W-1:0]  mag, quo_s;

  assign mag = dividend_i[SUM_W-1] ? (~dividend_i + 1'b1) : dividend_i;

  // restoring divide, one quotient bit a cycle
  always_comb begin
    shifted = {rem_q, quo_q[SUM_W-1]};
    trial   = shifted - {1'b0, div_q};
    fits    = shifted >= {1'b0, div_q};
    rem_d   = fits ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
    quo_d   = {quo_q[SUM_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DCNT_W'(SUM_W);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SUM_W-1];
      quo_q <= mag;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q && cnt_q != '0) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  // magnitude fits RATE_W bits once signed, so truncation is exact
  assign quo_s  = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign quot_o = quo_s[RATE_W-1:0];
  assign done_o = busy_q && (cnt_q == '0);

endmodule

@@ src/gbci_mac.sv @@
`timescale 1ns / 1ps

module gbci_mac (
  input  logic                                  clk_i,
  input  gbci_pkg::mac_ctrl_t                   ctrl_i,
  input  logic signed [gbci_pkg::DIFF_W-1:0]    diff_i,
  input  logic        [gbci_pkg::DELTA_W-1:0]   delta_i,
  input  logic signed [gbci_pkg::ANGLE_W-1:0]   acc_i,
  output logic signed [gbci_pkg::ANGLE_W-1:0]   sum_o
);
  import gbci_pkg::*;

  localparam logic signed [ADD_W-1:0] SAT_MAX =
    {{(ADD_W - ANGLE_W + 1){1'b0}}, {(ANGLE_W - 1){1'b1}}};
  localparam logic signed [ADD_W-1:0] SAT_MIN =
    {{(ADD_W - ANGLE_W + 1){1'b1}}, {(ANGLE_W - 1){1'b0}}};

  logic signed [PROD_W-1:0] prod_q;
  logic                     neg_q;
  logic signed [PROD_W-1:0] term;
  logic signed [ADD_W-1:0]  total;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      prod_q <= diff_i * $signed({1'b0, delta_i});
      neg_q  <= ctrl_i.neg;
    end
  end

  always_comb begin
    term  = neg_q ? -prod_q : prod_q;
    total = {{(ADD_W - ANGLE_W){acc_i[ANGLE_W-1]}}, acc_i}
          + {{(ADD_W - PROD_W){term[PROD_W-1]}}, term};
    if (total > SAT_MAX) begin
      sum_o = SAT_MAX[ANGLE_W-1:0];
    end else if (total < SAT_MIN) begin
      sum_o = SAT_MIN[ANGLE_W-1:0];
    end else begin
      sum_o = total[ANGLE_W-1:0];
    end
  end

endmodule
